@@ hdl/rgb_to_hsv_convert_core_macros.svh @@
// Assertion macros for the RGB to HSV conversion core checks.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef RGB_TO_HSV_CONVERT_CORE_MACROS_SVH
`define RGB_TO_HSV_CONVERT_CORE_MACROS_SVH

// Clocked check, off while reset is asserted.
`define RGBHSV_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("rgb_to_hsv_convert_core: check failed");

// A stalled valid stays up until the item is taken.
`define RGBHSV_ASSERT_STALL(label, vld, rdy) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (vld && !rdy) |=> vld) \
        else $error("rgb_to_hsv_convert_core: valid dropped under stall");

`endif

@@ hdl/rgbhsv_pkg.sv @@
// Shared types and constants of the RGB to HSV conversion core.
// No dependencies.
package rgbhsv_pkg;

    // Saturation is always Q0.16.
    localparam int SAT_BITS = 16;

    // Entries in the queue between classifier and divider pipeline.
    localparam int QUEUE_DEPTH = 4;

    // Hue offset in sixths of a turn, chosen by the classifier.
    typedef enum logic [1:0] {
        SECT_ZERO,  // red largest, green >= blue
        SECT_TWO,   // green largest
        SECT_FOUR,  // blue largest
        SECT_SIX    // red largest, green < blue
    } hue_sector_t;

endpackage

@@ hdl/rgbhsv_front.sv @@
// Classifier stage: finds largest/smallest channel and the hue sector.
// Depends on rgbhsv_pkg.
module rgbhsv_front
    import rgbhsv_pkg::*;
#(
    parameter int CHANNEL_BITS = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [CHANNEL_BITS-1:0] red,
    input  logic [CHANNEL_BITS-1:0] green,
    input  logic [CHANNEL_BITS-1:0] blue,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [CHANNEL_BITS-1:0] vmax,
    output logic [CHANNEL_BITS-1:0] vmin,
    output logic [CHANNEL_BITS-1:0] pos,
    output logic [CHANNEL_BITS-1:0] neg,
    output hue_sector_t             sector
);

    logic                    valid_reg;
    logic [CHANNEL_BITS-1:0] vmax_reg, vmax_next;
    logic [CHANNEL_BITS-1:0] vmin_reg, vmin_next;
    logic [CHANNEL_BITS-1:0] pos_reg, pos_next;
    logic [CHANNEL_BITS-1:0] neg_reg, neg_next;
    hue_sector_t             sector_reg, sector_next;
    logic                    ge_gb, ge_rg, ge_rb;
    logic                    load;

    assign load     = !valid_reg || out_ready;
    assign in_ready = load;

    // Three compares in parallel, then selection.
    always_comb
    begin
        ge_gb = (green >= blue);
        ge_rg = (red >= green);
        ge_rb = (red >= blue);
        priority if (ge_gb ? ge_rg : ge_rb)
        begin
            // red wins ties against both
            vmax_next   = red;
            vmin_next   = ge_gb ? blue : green;
            pos_next    = green;
            neg_next    = blue;
            sector_next = ge_gb ? SECT_ZERO : SECT_SIX;
        end
        else if (ge_gb)
        begin
            vmax_next   = green;
            vmin_next   = ge_rb ? blue : red;
            pos_next    = blue;
            neg_next    = red;
            sector_next = SECT_TWO;
        end
        else
        begin
            vmax_next   = blue;
            vmin_next   = ge_rg ? green : red;
            pos_next    = red;
            neg_next    = green;
            sector_next = SECT_FOUR;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (load && in_valid)
        begin
            vmax_reg   <= vmax_next;
            vmin_reg   <= vmin_next;
            pos_reg    <= pos_next;
            neg_reg    <= neg_next;
            sector_reg <= sector_next;
        end
    end

    assign out_valid = valid_reg;
    assign vmax      = vmax_reg;
    assign vmin      = vmin_reg;
    assign pos       = pos_reg;
    assign neg       = neg_reg;
    assign sector    = sector_reg;

endmodule

@@ hdl/rgbhsv_fifo.sv @@
// Small register queue decoupling classifier and divider pipeline.
// No dependencies; DEPTH must be a power of two.
module rgbhsv_fifo #(
    parameter int WIDTH = 66,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_data   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

@@ hdl/rgbhsv_back.sv @@
// Divider pipeline: chroma, hue numerator, then one quotient bit per stage
// for hue and saturation in lockstep. Depends on rgbhsv_pkg.
module rgbhsv_back
    import rgbhsv_pkg::*;
#(
    parameter int CHANNEL_BITS = 16,
    parameter int HUE_BITS     = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [CHANNEL_BITS-1:0] vmax,
    input  logic [CHANNEL_BITS-1:0] vmin,
    input  logic [CHANNEL_BITS-1:0] pos,
    input  logic [CHANNEL_BITS-1:0] neg,
    input  hue_sector_t             sector,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [HUE_BITS-1:0]     hue,
    output logic [SAT_BITS-1:0]     saturation,
    output logic [CHANNEL_BITS-1:0] brightness
);

    localparam int STAGES = (HUE_BITS > SAT_BITS) ? HUE_BITS : SAT_BITS;
    localparam int HW     = CHANNEL_BITS + 3;   // holds 6 * chroma
    localparam int CW     = CHANNEL_BITS;

    // Restoring step: remainder stays below the divisor, quotient shifts in.
    function automatic logic [HW+HUE_BITS-1:0] hue_step(
        input logic [HW-1:0]       rem,
        input logic [HW-1:0]       d,
        input logic [HUE_BITS-1:0] q
    );
        logic [HW:0] t;
        begin
            t = {rem, 1'b0};
            if (t >= {1'b0, d})
                hue_step = {HW'(t - {1'b0, d}), q[HUE_BITS-2:0], 1'b1};
            else
                hue_step = {t[HW-1:0], q[HUE_BITS-2:0], 1'b0};
        end
    endfunction

    // Remainder starting equal to the divisor gives all ones: full saturation.
    function automatic logic [CW+SAT_BITS-1:0] sat_step(
        input logic [CW-1:0]       rem,
        input logic [CW-1:0]       d,
        input logic [SAT_BITS-1:0] q
    );
        logic [CW:0] t;
        begin
            t = {rem, 1'b0};
            if (t >= {1'b0, d})
                sat_step = {CW'(t - {1'b0, d}), q[SAT_BITS-2:0], 1'b1};
            else
                sat_step = {t[CW-1:0], q[SAT_BITS-2:0], 1'b0};
        end
    endfunction

    logic en;

    // pre-stage: chroma and signed channel difference
    logic                p0_valid_reg;
    logic [CW-1:0]       p0_vmax_reg;
    logic [CW-1:0]       p0_chroma_reg;
    logic [CW:0]         p0_diff_reg;
    hue_sector_t         p0_sector_reg;

    // divider stages, index 0 is the loaded operand set
    logic [STAGES:0]     valid_reg;
    logic [HW-1:0]       hrem_reg   [STAGES+1];
    logic [HW-1:0]       hd_reg     [STAGES+1];
    logic [HUE_BITS-1:0] hq_reg     [STAGES+1];
    logic [CW-1:0]       srem_reg   [STAGES+1];
    logic [CW-1:0]       sd_reg     [STAGES+1];
    logic [SAT_BITS-1:0] sq_reg     [STAGES+1];
    logic [CW-1:0]       bright_reg [STAGES+1];

    logic [HW-1:0]       c3;
    logic [HW-1:0]       six_c;
    logic [HW-1:0]       offset;
    logic [HW-1:0]       hrem_next;
    logic [HW-1:0]       hd_next;
    logic [CW-1:0]       sd_next;

    assign en       = !valid_reg[STAGES] || out_ready;
    assign in_ready = en;

    // Hue numerator over 6*chroma lies in [0, 6*chroma); mod arithmetic is exact.
    always_comb
    begin
        c3    = {3'b000, p0_chroma_reg};
        six_c = (c3 << 2) + (c3 << 1);
        unique case (p0_sector_reg)
            SECT_ZERO: offset = '0;
            SECT_TWO:  offset = c3 << 1;
            SECT_FOUR: offset = c3 << 2;
            SECT_SIX:  offset = six_c;
        endcase
        hrem_next = offset + {{2{p0_diff_reg[CW]}}, p0_diff_reg};
        // grey pixel / black pixel: an all-ones divisor keeps the quotient at 0
        hd_next   = (p0_chroma_reg == '0) ? '1 : six_c;
        sd_next   = (p0_vmax_reg == '0) ? '1 : p0_vmax_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p0_valid_reg <= 1'b0;
            valid_reg    <= '0;
        end
        else if (en)
        begin
            p0_valid_reg <= in_valid;
            valid_reg    <= {valid_reg[STAGES-1:0], p0_valid_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p0_vmax_reg   <= vmax;
            p0_chroma_reg <= vmax - vmin;
            p0_diff_reg   <= {1'b0, pos} - {1'b0, neg};
            p0_sector_reg <= sector;

            hrem_reg[0]   <= hrem_next;
            hd_reg[0]     <= hd_next;
            hq_reg[0]     <= '0;
            srem_reg[0]   <= p0_chroma_reg;
            sd_reg[0]     <= sd_next;
            sq_reg[0]     <= '0;
            bright_reg[0] <= p0_vmax_reg;

            for (int k = 0; k < STAGES; k++)
            begin
                if (k < HUE_BITS)
                    {hrem_reg[k+1], hq_reg[k+1]} <= hue_step(hrem_reg[k], hd_reg[k],
                                                             hq_reg[k]);
                else
                begin
                    hrem_reg[k+1] <= hrem_reg[k];
                    hq_reg[k+1]   <= hq_reg[k];
                end
                if (k < SAT_BITS)
                    {srem_reg[k+1], sq_reg[k+1]} <= sat_step(srem_reg[k], sd_reg[k],
                                                             sq_reg[k]);
                else
                begin
                    srem_reg[k+1] <= srem_reg[k];
                    sq_reg[k+1]   <= sq_reg[k];
                end
                hd_reg[k+1]     <= hd_reg[k];
                sd_reg[k+1]     <= sd_reg[k];
                bright_reg[k+1] <= bright_reg[k];
            end
        end
    end

    assign out_valid  = valid_reg[STAGES];
    assign hue        = hq_reg[STAGES];
    assign saturation = sq_reg[STAGES];
    assign brightness = bright_reg[STAGES];

endmodule

@@ hdl/rgb_to_hsv_convert_core.sv @@
// Top level of the RGB to HSV conversion core.
// Depends on rgbhsv_pkg, rgbhsv_front, rgbhsv_fifo and rgbhsv_back.
//
// Converts one RGB pixel per clock into hue, saturation and brightness.
// Brightness is the largest channel (red wins all ties, green wins over
// blue), saturation is chroma/brightness in Q0.16 clipped to all ones, and
// hue is the truncated fraction of a full turn in Q0.HUE_BITS; a grey or
// black pixel gives hue 0, a black pixel saturation 0. Throughput is one
// item per cycle whenever hsv_ready is high. A pixel passes the classifier
// register, the queue, the operand stages and the divider pipeline, which
// retires one quotient bit per stage for hue and saturation side by side.
// A four-entry queue sits between the classifier and the divider pipeline,
// so pixels keep flowing into the front while a stalled output holds the
// back, and the last stage doubles as the output register. No state links
// pixels; there is no configuration.
module rgb_to_hsv_convert_core
    import rgbhsv_pkg::*;
#(
    parameter int CHANNEL_BITS = 16,
    parameter int HUE_BITS     = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    pixel_valid,
    output logic                    pixel_ready,
    input  logic [CHANNEL_BITS-1:0] red,
    input  logic [CHANNEL_BITS-1:0] green,
    input  logic [CHANNEL_BITS-1:0] blue,
    output logic                    hsv_valid,
    input  logic                    hsv_ready,
    output logic [HUE_BITS-1:0]     hue,
    output logic [SAT_BITS-1:0]     saturation,
    output logic [CHANNEL_BITS-1:0] brightness
);

    // queue word: vmax, vmin, pos, neg, sector
    localparam int QW = 4 * CHANNEL_BITS + 2;

    logic                    f_valid, f_ready;
    logic [CHANNEL_BITS-1:0] f_vmax, f_vmin, f_pos, f_neg;
    hue_sector_t             f_sector;

    logic                    q_valid, q_ready;
    logic [QW-1:0]           q_data;

    // classify each pixel: extremes, difference operands, hue sector
    rgbhsv_front #(
        .CHANNEL_BITS(CHANNEL_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pixel_valid),
        .in_ready  (pixel_ready),
        .red       (red),
        .green     (green),
        .blue      (blue),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .vmax      (f_vmax),
        .vmin      (f_vmin),
        .pos       (f_pos),
        .neg       (f_neg),
        .sector    (f_sector)
    );

    // decoupling queue
    rgbhsv_fifo #(
        .WIDTH(QW),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  ({f_vmax, f_vmin, f_pos, f_neg, f_sector}),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (q_data)
    );

    // two bit-per-stage dividers in lockstep
    rgbhsv_back #(
        .CHANNEL_BITS(CHANNEL_BITS),
        .HUE_BITS    (HUE_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (q_valid),
        .in_ready   (q_ready),
        .vmax       (q_data[QW-1 -: CHANNEL_BITS]),
        .vmin       (q_data[QW-1-CHANNEL_BITS -: CHANNEL_BITS]),
        .pos        (q_data[QW-1-2*CHANNEL_BITS -: CHANNEL_BITS]),
        .neg        (q_data[QW-1-3*CHANNEL_BITS -: CHANNEL_BITS]),
        .sector     (hue_sector_t'(q_data[1:0])),
        .out_valid  (hsv_valid),
        .out_ready  (hsv_ready),
        .hue        (hue),
        .saturation (saturation),
        .brightness (brightness)
    );

endmodule

@@ hdl/rgbhsv_checker.sv @@
// Port-level checks of the RGB to HSV conversion core, bound to the top.
// Depends on rgbhsv_pkg and rgb_to_hsv_convert_core_macros.svh.
`include "rgb_to_hsv_convert_core_macros.svh"

module rgbhsv_checker
    import rgbhsv_pkg::*;
#(
    parameter int CHANNEL_BITS = 16,
    parameter int HUE_BITS     = 16
) (
    input logic                    clk,
    input logic                    rst_n,
    input logic                    pixel_valid,
    input logic                    pixel_ready,
    input logic                    hsv_valid,
    input logic                    hsv_ready,
    input logic [HUE_BITS-1:0]     hue,
    input logic [SAT_BITS-1:0]     saturation,
    input logic [CHANNEL_BITS-1:0] brightness
);

    // items accepted but not yet delivered
    logic [5:0] pending_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pending_reg <= '0;
        else
            pending_reg <= pending_reg + 6'(pixel_valid && pixel_ready)
                                       - 6'(hsv_valid && hsv_ready);
    end

    `RGBHSV_ASSERT_STALL(a_out_stall, hsv_valid, hsv_ready)
    `RGBHSV_ASSERT(a_no_phantom, hsv_valid |-> (pending_reg != '0))
    `RGBHSV_ASSERT(a_idle_ready, (pending_reg == '0) |-> pixel_ready)
    `RGBHSV_ASSERT(a_black_px, (hsv_valid && brightness == '0) |-> (saturation == '0 && hue == '0))

endmodule

bind rgb_to_hsv_convert_core rgbhsv_checker #(
    .CHANNEL_BITS(CHANNEL_BITS),
    .HUE_BITS    (HUE_BITS)
) u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .pixel_valid (pixel_valid),
    .pixel_ready (pixel_ready),
    .hsv_valid   (hsv_valid),
    .hsv_ready   (hsv_ready),
    .hue         (hue),
    .saturation  (saturation),
    .brightness  (brightness)
);

@@ dv/rgb_to_hsv_convert_core_test.sv @@
// Self-checking testbench for rgb_to_hsv_convert_core: directed corner pixels, then random
// pixels under several sender-idle and receiver-stall mixes, checked against a local HSV model.
// Depends on rgbhsv_pkg and the rgb_to_hsv_convert_core RTL.
module rgb_to_hsv_convert_core_test
    import rgbhsv_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CHANNEL_BITS = 16;
    localparam int HUE_BITS     = 16;

    // Allow a good margin after the last result so a stray extra result still gets seen.
    localparam int DRAIN_CYCLES   = 60;
    // Cycles without any handshake before the run is declared hung. The longest honest
    // quiet spell is a drain pause or a long random stall, both well under this.
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int REPORT_LIMIT   = 10;

    typedef logic [CHANNEL_BITS-1:0] channel_t;

    typedef struct packed {
        logic [HUE_BITS-1:0]     hue;
        logic [SAT_BITS-1:0]     saturation;
        logic [CHANNEL_BITS-1:0] brightness;
    } hsv_t;

    logic     clk         = 1'b0;
    logic     rst_n       = 1'b0;
    logic     pixel_valid = 1'b0;
    logic     pixel_ready;
    channel_t red         = '0;
    channel_t green       = '0;
    channel_t blue        = '0;
    logic     hsv_valid;
    logic     hsv_ready   = 1'b0;
    logic [HUE_BITS-1:0]     hue;
    logic [SAT_BITS-1:0]     saturation;
    logic [CHANNEL_BITS-1:0] brightness;

    hsv_t expected_hsv_q[$];

    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int pixels_sent        = 0;
    int directed_pixels    = 0;
    int results_checked    = 0;
    int mismatch_count     = 0;
    int idle_cycles        = 0;

    rgb_to_hsv_convert_core #(
        .CHANNEL_BITS(CHANNEL_BITS),
        .HUE_BITS    (HUE_BITS)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .pixel_valid(pixel_valid),
        .pixel_ready(pixel_ready),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .hsv_valid  (hsv_valid),
        .hsv_ready  (hsv_ready),
        .hue        (hue),
        .saturation (saturation),
        .brightness (brightness)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // HSV model
    // ------------------------------------------------------------------

    // acc + (a - b) * 2^HUE_BITS, keeping the sign of a - b. acc always holds enough
    // turn offset that the sum stays non-negative.
    function automatic logic [63:0] add_scaled_diff(input logic [63:0] acc,
                                                    input logic [63:0] a,
                                                    input logic [63:0] b);
        if (a >= b)
            return acc + ((a - b) << HUE_BITS);
        return acc - ((b - a) << HUE_BITS);
    endfunction

    function automatic hsv_t predict_hsv(input channel_t r_in, input channel_t g_in,
                                         input channel_t b_in);
        logic [63:0] r;
        logic [63:0] g;
        logic [63:0] b;
        logic [63:0] vmax;
        logic [63:0] vmin;
        logic [63:0] chroma;
        logic [63:0] unit;
        logic [63:0] num;
        logic [63:0] quo;
        logic [63:0] sat;
        hue_sector_t sector;
        hsv_t        res;
        r = 64'(r_in);
        g = 64'(g_in);
        b = 64'(b_in);
        // Red wins every tie for largest, green wins over blue.
        if (r >= g && r >= b)
        begin
            vmax   = r;
            vmin   = (g < b) ? g : b;
            sector = (g >= b) ? SECT_ZERO : SECT_SIX;
        end
        else if (g >= b)
        begin
            vmax   = g;
            vmin   = (b < r) ? b : r;
            sector = SECT_TWO;
        end
        else
        begin
            vmax   = b;
            vmin   = (g < r) ? g : r;
            sector = SECT_FOUR;
        end
        chroma = vmax - vmin;

        // Hue: numerator over 6*chroma, offset in sixths of a turn. Grey gives 0.
        quo = '0;
        if (chroma != 0)
        begin
            unit = chroma << HUE_BITS;
            case (sector)
                SECT_ZERO: num = add_scaled_diff(64'd0, g, b);
                SECT_SIX:  num = add_scaled_diff(6 * unit, g, b);
                SECT_TWO:  num = add_scaled_diff(2 * unit, b, r);
                default:   num = add_scaled_diff(4 * unit, r, g);
            endcase
            quo = num / (6 * chroma);
        end

        // Saturation clips when chroma equals value; black gives 0.
        sat = '0;
        if (vmax != 0)
        begin
            sat = (chroma << SAT_BITS) / vmax;
            if (sat > {SAT_BITS{1'b1}})
                sat = {SAT_BITS{1'b1}};
        end

        res.hue        = quo[HUE_BITS-1:0];
        res.saturation = sat[SAT_BITS-1:0];
        res.brightness = vmax[CHANNEL_BITS-1:0];
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    task automatic note_mismatch(input string what, input hsv_t want, input hsv_t got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("[%0t] %s: expected h=%h s=%h v=%h, got h=%h s=%h v=%h", $realtime,
                     what, want.hue, want.saturation, want.brightness,
                     got.hue, got.saturation, got.brightness);
    endtask

    // Input acceptance and output acceptance are handled in one process so that the order
    // of push and pop within a step is fixed.
    always @(posedge clk)
    begin
        hsv_t got;
        hsv_t want;
        if (rst_n && pixel_valid && pixel_ready)
            expected_hsv_q.push_back(predict_hsv(red, green, blue));
        if (rst_n && hsv_valid && hsv_ready)
        begin
            got = '{hue, saturation, brightness};
            results_checked++;
            if (expected_hsv_q.size() == 0)
                note_mismatch("result with no pixel pending", '0, got);
            else
            begin
                want = expected_hsv_q.pop_front();
                if (got.hue !== want.hue || got.saturation !== want.saturation ||
                    got.brightness !== want.brightness)
                    note_mismatch("wrong result", want, got);
            end
        end
    end

    // Hang detector: any handshake on either side restarts the count. A result that never
    // arrives ends up here.
    always @(posedge clk)
    begin
        if ((pixel_valid && pixel_ready) || (hsv_valid && hsv_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Timeout: %0d cycles without a handshake, %0d results outstanding",
                     idle_cycles, expected_hsv_q.size());
            $display("Some tests failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Output side: ready is redrawn each cycle at the current stall rate.
    always @(negedge clk)
        hsv_ready <= ($urandom_range(99) >= receiver_stall_pct);

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Offers one item; valid stays up with a fixed payload until it is taken. Valid is
    // never dropped and raised in the same step: a following item just replaces the payload.
    task automatic send_pixel(input channel_t r, input channel_t g, input channel_t b);
        @(negedge clk);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            pixel_valid <= 1'b0;
            @(negedge clk);
        end
        pixel_valid <= 1'b1;
        red         <= r;
        green       <= g;
        blue        <= b;
        do
            @(posedge clk);
        while (!pixel_ready);
        pixels_sent++;
    endtask

    task automatic wait_for_drain();
        @(negedge clk);
        pixel_valid <= 1'b0;
        while (expected_hsv_q.size() != 0)
            @(posedge clk);
    endtask

    // Random pixel with weight on grey, ties and near-equal channels, where the
    // classifier and the small-chroma division get exercised.
    task automatic random_pixel(output channel_t r, output channel_t g, output channel_t b);
        channel_t base;
        channel_t picks[6];
        base  = CHANNEL_BITS'($urandom);
        r     = CHANNEL_BITS'($urandom);
        g     = CHANNEL_BITS'($urandom);
        b     = CHANNEL_BITS'($urandom);
        picks = '{'0, CHANNEL_BITS'(1), {1'b1, {(CHANNEL_BITS-1){1'b0}}}, '1,
                  {{(CHANNEL_BITS-1){1'b1}}, 1'b0}, CHANNEL_BITS'($urandom_range(15))};
        case ($urandom_range(9))
            4: begin r = base; g = base; b = base; end
            5: g = r;
            6: b = g;
            7: b = r;
            8:
            begin
                r = base ^ CHANNEL_BITS'($urandom_range(7));
                g = base ^ CHANNEL_BITS'($urandom_range(7));
                b = base ^ CHANNEL_BITS'($urandom_range(7));
            end
            9:
            begin
                r = picks[$urandom_range(5)];
                g = picks[$urandom_range(5)];
                b = picks[$urandom_range(5)];
            end
            default: ;
        endcase
    endtask

    task automatic run_random_pixels(input int count);
        channel_t r;
        channel_t g;
        channel_t b;
        repeat (count)
        begin
            random_pixel(r, g, b);
            send_pixel(r, g, b);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Black, white, single channels at full scale, grey, tiny chroma, full saturation.
    task automatic test_corner_pixels();
        send_pixel('0, '0, '0);
        send_pixel('1, '1, '1);
        send_pixel('1, '0, '0);
        send_pixel('0, '1, '0);
        send_pixel('0, '0, '1);
        send_pixel(16'h1000, 16'h1000, 16'h1000);
        send_pixel(16'h0001, 16'h0000, 16'h0000);
        send_pixel(16'h0000, 16'h0000, 16'h0001);
        send_pixel(16'hFFFF, 16'hFFFE, 16'hFFFE);
        send_pixel(16'hAAAA, 16'h5555, 16'h0F0F);
        send_pixel(16'h5555, 16'hAAAA, 16'hF0F0);
        wait_for_drain();
    endtask

    // Largest-channel ties: red beats both, green beats blue.
    task automatic test_max_channel_ties();
        send_pixel('1, '1, '0);
        send_pixel('0, '1, '1);
        send_pixel('1, '0, '1);
        send_pixel(16'h8000, 16'h8000, 16'h1234);
        send_pixel(16'h0100, 16'h0200, 16'h0200);
        send_pixel(16'h0300, 16'h0001, 16'h0300);
        wait_for_drain();
    endtask

    // Pixels in every hue sector, including red-largest with blue above green, which sits
    // just under a full turn.
    task automatic test_hue_sectors();
        send_pixel(16'h3E80, 16'h0C80, 16'h0380);
        send_pixel(16'h3E80, 16'h0380, 16'h0C80);
        send_pixel(16'hFFFF, 16'h0000, 16'h0001);
        send_pixel(16'h0200, 16'h7000, 16'h0100);
        send_pixel(16'h0100, 16'h7000, 16'h0200);
        send_pixel(16'h0100, 16'h0200, 16'h7000);
        send_pixel(16'h0200, 16'h0100, 16'h7000);
        wait_for_drain();
        directed_pixels = pixels_sent;
    endtask

    task automatic test_steady_stream();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        run_random_pixels(400);
        wait_for_drain();
    endtask

    task automatic test_idle_sender();
        sender_idle_pct    = 65;
        receiver_stall_pct = 0;
        run_random_pixels(350);
        wait_for_drain();
    endtask

    // Heavy stalls fill the internal queue and hold the back of the pipeline.
    task automatic test_output_backpressure();
        sender_idle_pct    = 0;
        receiver_stall_pct = 65;
        run_random_pixels(350);
        wait_for_drain();
    endtask

    task automatic test_mixed_idle();
        sender_idle_pct    = 31;
        receiver_stall_pct = 31;
        run_random_pixels(300);
        wait_for_drain();
    endtask

    // Short bursts, each followed by a full pipeline drain before the next one.
    task automatic test_burst_then_drain();
        sender_idle_pct    = 0;
        receiver_stall_pct = 31;
        repeat (5)
        begin
            run_random_pixels(20);
            wait_for_drain();
        end
    endtask

    initial
    begin
        repeat (11)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_corner_pixels();
        test_max_channel_ties();
        test_hue_sectors();
        test_steady_stream();
        test_idle_sender();
        test_output_backpressure();
        test_mixed_idle();
        test_burst_then_drain();

        // Everything expected has come; linger past the latency to catch extras.
        wait_for_drain();
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        $display("Sent %0d pixels (%0d directed), checked %0d results, %0d mismatches,",
                 pixels_sent, directed_pixels, results_checked, mismatch_count);
        $display("over free-running, idle-sender, stalled-receiver, mixed and burst phases.");
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
